// ===== src/pim_pkg.sv =====
`timescale 1ns / 1ps

package pim_pkg;

    localparam int KEY_W     = 16;
    localparam int OUT_W     = 8;
    localparam int CHAN_W    = 8;
    localparam int OPCODE_W  = 1;

    localparam logic [OPCODE_W-1:0] OP_LOAD = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_MAP  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic rd_en;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic last_addr;
    } t_status;

    function automatic logic [KEY_W-1:0] make_key(
        input logic [CHAN_W-1:0] r,
        input logic [CHAN_W-1:0] g,
        input logic [CHAN_W-1:0] b,
        input logic [CHAN_W-1:0] a
    );
        return {r[7:4], g[7:4], b[7:4], a[7:4]};
    endfunction

endpackage

// ===== src/pim_ctrl.sv =====
`timescale 1ns / 1ps

module pim_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic [pim_pkg::OPCODE_W-1:0]       i_opcode,
    input  logic                               i_out_stall,
    input  pim_pkg::t_status                   i_status,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    output pim_pkg::t_cmd                      o_cmd
);

    pim_pkg::t_state r_state;
    pim_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            w_accept;
    logic            w_out_free;

    assign o_in_stall  = (r_state != pim_pkg::S_IDLE);
    assign w_accept    = i_in_valid && (r_state == pim_pkg::S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pim_pkg::S_IDLE: begin
                if (w_accept && (i_opcode == pim_pkg::OP_MAP)) begin
                    n_state = pim_pkg::S_SCAN;
                end
            end
            pim_pkg::S_SCAN: begin
                if (i_status.last_addr) begin
                    n_state = pim_pkg::S_LAST;
                end
            end
            pim_pkg::S_LAST: begin
                n_state = pim_pkg::S_OUT;
            end
            pim_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = pim_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pim_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            pim_pkg::S_IDLE: begin
                o_cmd.load       = w_accept && (i_opcode == pim_pkg::OP_LOAD);
                o_cmd.scan_start = w_accept && (i_opcode == pim_pkg::OP_MAP);
            end
            pim_pkg::S_SCAN: begin
                o_cmd.rd_en = 1'b1;
            end
            pim_pkg::S_LAST: begin
                o_cmd = '0;
            end
            pim_pkg::S_OUT: begin
                o_cmd.out_load = w_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pim_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== src/pim_datapath.sv =====
`timescale 1ns / 1ps

module pim_datapath #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pim_pkg::t_cmd                      i_cmd,
    input  logic [7:0]                         i_entry_index,
    input  logic [pim_pkg::CHAN_W-1:0]         i_red_level,
    input  logic [pim_pkg::CHAN_W-1:0]         i_green_level,
    input  logic [pim_pkg::CHAN_W-1:0]         i_blue_level,
    input  logic [pim_pkg::CHAN_W-1:0]         i_alpha_level,
    input  logic [pim_pkg::KEY_W-1:0]          i_pixel_value,
    output pim_pkg::t_status                   o_status,
    output logic [pim_pkg::OUT_W-1:0]          o_palette_index
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam int KW = pim_pkg::KEY_W;

    logic [KW-1:0]              r_key_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] r_key_valid;
    logic                       w_in_range;
    logic [AW-1:0]              w_wr_addr;

    logic [AW-1:0]              r_addr;
    logic [KW-1:0]              r_pixel;
    logic [KW-1:0]              r_rd_data;
    logic                       r_rd_vbit;
    logic                       r_rd_pend;
    logic [AW-1:0]              r_rd_slot;
    logic [KW-1:0]              w_key;

    logic                       r_lo_found;
    logic [KW-1:0]              r_lo_key;
    logic [AW-1:0]              r_lo_slot;
    logic                       r_hi_found;
    logic [KW-1:0]              r_hi_key;
    logic [AW-1:0]              r_hi_slot;

    logic [KW:0]                w_pair_sum;
    logic [KW:0]                w_twice_pixel;
    logic                       w_take_hi;
    logic [pim_pkg::OUT_W-1:0]  r_out_index;

    assign w_in_range = ({1'b0, i_entry_index} < 9'(PALETTE_ENTRIES));
    assign w_wr_addr  = i_entry_index[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_in_range) begin
            r_key_mem[w_wr_addr] <= pim_pkg::make_key(i_red_level, i_green_level,
                                                      i_blue_level, i_alpha_level);
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_key_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_valid <= '0;
        end else if (i_cmd.load && w_in_range) begin
            r_key_valid[w_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
            r_addr    <= '0;
        end else begin
            r_rd_pend <= i_cmd.rd_en;
            if (i_cmd.scan_start) begin
                r_addr <= '0;
            end else if (i_cmd.rd_en) begin
                r_addr <= r_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_pixel <= i_pixel_value;
        end
        if (i_cmd.rd_en) begin
            r_rd_vbit <= r_key_valid[r_addr];
            r_rd_slot <= r_addr;
        end
    end

    assign o_status.last_addr = (r_addr == AW'(PALETTE_ENTRIES - 1));

    assign w_key = r_rd_vbit ? r_rd_data : '0;

    // nearest key at or below the pixel, highest slot on ties
    // nearest key above the pixel, lowest slot on ties
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_lo_found <= 1'b0;
            r_hi_found <= 1'b0;
        end else if (r_rd_pend) begin
            if (w_key <= r_pixel) begin
                if (!r_lo_found || (w_key >= r_lo_key)) begin
                    r_lo_found <= 1'b1;
                    r_lo_key   <= w_key;
                    r_lo_slot  <= r_rd_slot;
                end
            end else begin
                if (!r_hi_found || (w_key < r_hi_key)) begin
                    r_hi_found <= 1'b1;
                    r_hi_key   <= w_key;
                    r_hi_slot  <= r_rd_slot;
                end
            end
        end
    end

    assign w_pair_sum    = {1'b0, r_hi_key} + {1'b0, r_lo_key};
    assign w_twice_pixel = {r_pixel, 1'b0};
    assign w_take_hi     = !r_lo_found || (r_hi_found && (w_pair_sum <= w_twice_pixel));

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_index <= w_take_hi ? pim_pkg::OUT_W'(r_hi_slot)
                                     : pim_pkg::OUT_W'(r_lo_slot);
        end
    end

    assign o_palette_index = r_out_index;

endmodule

// ===== src/palette_index_mapper_top.sv =====
`timescale 1ns / 1ps
// load item: accepted while idle, next item may follow in the next cycle
// map item: result set by a scan of the key memory, one entry per cycle
//   through its single read port
// one map item scanned at a time; result sits in an output register
// synchronous active-low reset clears all key valid bits (keys then read as zero) and the output valid
module palette_index_mapper_top #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [pim_pkg::OPCODE_W-1:0]       i_opcode,
    input  logic [7:0]                         i_entry_index,
    input  logic [pim_pkg::CHAN_W-1:0]         i_red_level,
    input  logic [pim_pkg::CHAN_W-1:0]         i_green_level,
    input  logic [pim_pkg::CHAN_W-1:0]         i_blue_level,
    input  logic [pim_pkg::CHAN_W-1:0]         i_alpha_level,
    input  logic [pim_pkg::KEY_W-1:0]          i_pixel_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [pim_pkg::OUT_W-1:0]          o_palette_index
);

    pim_pkg::t_cmd    w_cmd;
    pim_pkg::t_status w_status;

    pim_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    pim_datapath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_entry_index   (i_entry_index),
        .i_red_level     (i_red_level),
        .i_green_level   (i_green_level),
        .i_blue_level    (i_blue_level),
        .i_alpha_level   (i_alpha_level),
        .i_pixel_value   (i_pixel_value),
        .o_status        (w_status),
        .o_palette_index (o_palette_index)
    );

endmodule

// ===== src/pim_checker.sv =====
`timescale 1ns / 1ps

module pim_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic [pim_pkg::OPCODE_W-1:0]       i_opcode,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [pim_pkg::OUT_W-1:0]          o_palette_index
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_palette_index))
        else $error("result changed while stalled");

    a_map_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_opcode == pim_pkg::OP_MAP) |=> o_in_stall)
        else $error("map item did not start a lookup");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_opcode == pim_pkg::OP_LOAD) |=> !o_in_stall)
        else $error("load item blocked the input");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall && !o_out_valid |=> !o_out_valid)
        else $error("result without a map item");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear control");

endmodule

bind palette_index_mapper_top pim_checker u_pim_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int SLOTS      = 256;
    localparam int MAP_CYCLES = SLOTS + 3;
    localparam int LIMIT      = 3000000;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic [pim_pkg::OPCODE_W-1:0] i_opcode = pim_pkg::OP_LOAD;
    logic [7:0]                   i_entry_index = '0;
    logic [pim_pkg::CHAN_W-1:0]   i_red_level = '0;
    logic [pim_pkg::CHAN_W-1:0]   i_green_level = '0;
    logic [pim_pkg::CHAN_W-1:0]   i_blue_level = '0;
    logic [pim_pkg::CHAN_W-1:0]   i_alpha_level = '0;
    logic [pim_pkg::KEY_W-1:0]    i_pixel_value = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic [pim_pkg::OUT_W-1:0]    o_palette_index;

    palette_index_mapper_top #(.PALETTE_ENTRIES(SLOTS)) DUT (.*);

    always #6 i_clk = ~i_clk;

    // shadow copy of the palette
    logic [pim_pkg::KEY_W-1:0] key_mem [SLOTS];
    int                        sorted_slot [SLOTS];
    bit                        order_stale;
    logic [pim_pkg::OUT_W-1:0] index_queue [$];

    bit tx_gaps, rx_gaps;
    int hold_cycles = 0;
    int hold_requests = 0;
    int hold_taken = 0;
    int cycle_count, mismatches, results_seen, loads_sent, maps_sent;

    function automatic void sort_palette();
        int j;
        for (int i = 0; i < SLOTS; i++) begin
            j = i;
            while (j > 0 && key_mem[sorted_slot[j-1]] > key_mem[i]) begin
                sorted_slot[j] = sorted_slot[j-1];
                j--;
            end
            sorted_slot[j] = i;
        end
        order_stale = 0;
    endfunction

    function automatic logic [pim_pkg::OUT_W-1:0] lookup_index(
        logic [pim_pkg::KEY_W-1:0] pix);
        int key, lo, hi;
        logic [pim_pkg::OUT_W-1:0] pick;
        pick = '0;
        if (order_stale) sort_palette();
        for (int i = 0; i < SLOTS; i++) begin
            key = key_mem[sorted_slot[i]];
            lo = (i == 0) ? 0 : key - (key - int'(key_mem[sorted_slot[i-1]])) / 2;
            if (i == SLOTS - 1) begin
                hi = 65535;
            end else begin
                hi = key + (int'(key_mem[sorted_slot[i+1]]) - key) / 2;
                if (hi % 2 == 0) hi++;
            end
            if (hi > 65535) hi = 65535;
            if (int'(pix) >= lo && int'(pix) <= hi) pick = sorted_slot[i][7:0];
        end
        return pick;
    endfunction

    task automatic send_item(input logic [pim_pkg::OPCODE_W-1:0] op,
                             input logic [7:0] slot,
                             input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [7:0] a,
                             input logic [15:0] pix);
        while (tx_gaps && $urandom_range(99) < 8) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_entry_index <= slot;
        i_red_level   <= r;
        i_green_level <= g;
        i_blue_level  <= b;
        i_alpha_level <= a;
        i_pixel_value <= pix;
        do @(posedge i_clk); while (o_in_stall);
        if (op == pim_pkg::OP_LOAD) begin
            key_mem[slot] = {r[7:4], g[7:4], b[7:4], a[7:4]};
            order_stale = 1;
            loads_sent++;
        end else begin
            index_queue.push_back(lookup_index(pix));
            maps_sent++;
        end
    endtask

    task automatic load_rand(input logic [7:0] slot);
        send_item(pim_pkg::OP_LOAD, slot, 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 16'($urandom));
    endtask

    task automatic map_pixel(input logic [15:0] pix);
        send_item(pim_pkg::OP_MAP, 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), pix);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (index_queue.size() != 0) @(posedge i_clk);
    endtask

    // pixel near a stored key or anywhere
    function automatic logic [15:0] pick_pixel();
        int base;
        if ($urandom_range(2) == 0) return 16'($urandom);
        base = int'(key_mem[$urandom_range(SLOTS-1)]) + $urandom_range(64) - 32;
        if (base < 0) base = 0;
        if (base > 65535) base = 65535;
        return base[15:0];
    endfunction

    task automatic test_reset_palette();
        map_pixel(16'h0000);
        map_pixel(16'hffff);
        map_pixel(16'h8000);
        wait_drained();
    endtask

    task automatic test_directed();
        send_item(pim_pkg::OP_LOAD, 8'd0, 8'hff, 8'hff, 8'hff, 8'hff, 16'h1234);
        map_pixel(16'hffff);
        map_pixel(16'h0000);
        send_item(pim_pkg::OP_LOAD, 8'd255, 8'h0f, 8'h0f, 8'h0f, 8'h0f, 16'hffff);
        send_item(pim_pkg::OP_LOAD, 8'd128, 8'h80, 8'h00, 8'h00, 8'h00, 16'h0);
        send_item(pim_pkg::OP_LOAD, 8'd7, 8'h00, 8'hf0, 8'h00, 8'h00, 16'h0);
        send_item(pim_pkg::OP_LOAD, 8'd9, 8'h00, 8'h00, 8'hf0, 8'h00, 16'h0);
        send_item(pim_pkg::OP_LOAD, 8'd11, 8'h00, 8'h00, 8'h00, 8'hf0, 16'h0);
        map_pixel(16'h0000);
        map_pixel(16'h4000);
        map_pixel(16'h8000);
        map_pixel(16'hc000);
        map_pixel(16'hfffe);
        map_pixel(16'h000f);
        map_pixel(16'h00f0);
        // tie between two slots with the same key
        send_item(pim_pkg::OP_LOAD, 8'd200, 8'h80, 8'h0a, 8'h05, 8'h03, 16'h0);
        map_pixel(16'h8000);
        map_pixel(16'h8001);
        wait_drained();
    endtask

    task automatic test_random(input int n_items);
        int sent, n;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                n = $urandom_range(6, 1);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(1)) map_pixel(16'($urandom));
                    else load_rand(8'($urandom));
                end
            end else begin
                n = $urandom_range(5);
                for (int i = 0; i < n; i++) load_rand(8'($urandom));
                sent += n;
                n = $urandom_range(6, 1);
                for (int i = 0; i < n; i++) map_pixel(pick_pixel());
            end
            sent += n;
            if ($urandom_range(15) == 0) wait_drained();
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_requests++;
        for (int i = 0; i < 8; i++) begin
            load_rand(8'($urandom));
            map_pixel(pick_pixel());
        end
        wait_drained();
    endtask

    task automatic test_no_idling();
        tx_gaps = 0;
        rx_gaps = 0;
        test_random(150);
        tx_gaps = 1;
        rx_gaps = 1;
    endtask

    // receiver stall
    always @(posedge i_clk) begin
        if (hold_taken != hold_requests) begin
            hold_taken  <= hold_requests;
            hold_cycles <= 3 * MAP_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= rx_gaps && ($urandom_range(99) < 8);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (index_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: palette_index %0d", o_palette_index);
            end else if (index_queue[0] !== o_palette_index) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("palette_index mismatch: expected %0d actual %0d",
                             index_queue[0], o_palette_index);
                void'(index_queue.pop_front());
            end else begin
                void'(index_queue.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int wait_cycles;
        foreach (key_mem[i]) key_mem[i] = '0;
        order_stale = 1;
        tx_gaps = 1;
        rx_gaps = 1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_palette();
        test_directed();
        test_backpressure();
        test_random(500);
        test_no_idling();
        test_backpressure();
        test_random(450);
        wait_drained();
        wait_cycles = 0;
        while (wait_cycles < 2 * MAP_CYCLES) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (index_queue.size() != 0) mismatches++;
        $display("covered %0d palette loads and %0d pixel maps, %0d results checked",
                 loads_sent, maps_sent, results_seen);
        $display("with random idling, long output hold-offs and a no-idle stretch");
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/pim_pkg.sv
src/pim_ctrl.sv
src/pim_datapath.sv
src/palette_index_mapper_top.sv
src/pim_checker.sv
tb/tb_top.sv
